@@ hdl/pxab_pkg.sv @@
// Shared types, format codes and channel layout for the pixel store with alpha blend.
`default_nettype none

package pxab_pkg;

    // Pixel format codes (byte order of one pixel).
    localparam logic [2:0] FMT_RGB  = 3'd0;
    localparam logic [2:0] FMT_RGBA = 3'd1;
    localparam logic [2:0] FMT_ARGB = 3'd2;
    localparam logic [2:0] FMT_BGR  = 3'd3;
    localparam logic [2:0] FMT_BGRA = 3'd4;
    localparam logic [2:0] FMT_ABGR = 3'd5;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Channel numbers inside one pixel transaction.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    // Request codes.
    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [2:0] FMT_RESET    = FMT_RGBA;
    localparam logic [8:0] WIDTH_RESET  = 9'd256;
    localparam logic [8:0] HEIGHT_RESET = 9'd256;

    typedef struct packed {
        logic       load;
        logic       mul_y;
        logic       base;
        logic       rd;
        logic       cap;
        logic       mul;
        logic       div;
        logic       wr;
        logic       emit;
        logic [1:0] ch;
    } pxab_cmd_t;

    typedef struct packed {
        logic skip;
        logic is_get;
        logic has_alpha;
    } pxab_stat_t;

    function automatic logic fmt_has_alpha(input logic [2:0] fmt);
        return (fmt != FMT_RGB) && (fmt != FMT_BGR);
    endfunction

    // Byte offset of a channel within a pixel for a given format.
    function automatic logic [1:0] chan_pos(input logic [2:0] fmt, input logic [1:0] ch);
        logic [1:0] pos;
        pos = 2'd0;
        case (fmt)
            FMT_RGB, FMT_RGBA: pos = ch;
            FMT_ARGB: pos = (ch == CH_ALPHA) ? 2'd0 : ch + 2'd1;
            FMT_BGR, FMT_BGRA: pos = (ch == CH_ALPHA) ? 2'd3 : 2'd2 - ch;
            FMT_ABGR: pos = 2'd3 - ch;
            default: pos = 2'd0;
        endcase
        return pos;
    endfunction

endpackage

`default_nettype wire

@@ hdl/pxab_ctrl.sv @@
// Controller state machine that sequences address, read, blend and write steps.
`default_nettype none

module pxab_ctrl
    import pxab_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire pxab_stat_t stat,
    output pxab_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MULY = 4'd1;
    localparam logic [3:0] S_BASE = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_CAP  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] ch_reg;
    logic [1:0] ch_next;
    logic [1:0] last_ch;

    assign last_ch = stat.has_alpha ? CH_ALPHA : CH_BLUE;
    assign busy    = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MULY;
                end
            end
            S_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = stat.skip ? S_DONE : S_BASE;
            end
            S_BASE:
            begin
                cmd.base   = 1'b1;
                ch_next    = CH_RED;
                if (stat.is_get || stat.has_alpha)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = stat.is_get ? S_CAP : S_MUL;
            end
            S_CAP:
            begin
                cmd.cap = 1'b1;
                if (ch_reg == last_ch)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.wr = 1'b1;
                if (ch_reg == last_ch)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ch_next = ch_reg + 2'd1;
                    // The alpha byte is written as opaque without a read.
                    if (stat.has_alpha && (ch_reg != CH_BLUE))
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_WR;
                    end
                end
            end
            S_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= CH_RED;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    a_wr_only_on_put: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> !stat.is_get)
        else $error("store written during a get transaction");

    a_cap_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap |-> $past(cmd.rd))
        else $error("capture without a preceding read");

    a_mul_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> ($past(cmd.rd) && stat.has_alpha))
        else $error("blend multiply without fresh read data");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !busy)
        else $error("controller still busy after the result");

endmodule

`default_nettype wire

@@ hdl/pxab_dp.sv @@
// Datapath: request registers, address arithmetic, byte store and blend unit.
`default_nettype none

module pxab_dp
    import pxab_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire pxab_cmd_t  cmd,
    output pxab_stat_t      stat,
    input  wire logic [2:0] fmt,
    input  wire logic [8:0] width,
    input  wire logic [8:0] height,
    input  wire logic       req_type,
    input  wire logic [7:0] x_pos,
    input  wire logic [7:0] y_pos,
    input  wire logic [7:0] red_in,
    input  wire logic [7:0] green_in,
    input  wire logic [7:0] blue_in,
    input  wire logic [7:0] alpha_in,
    output logic            done,
    output logic [7:0]      red_out,
    output logic [7:0]      green_out,
    output logic [7:0]      blue_out,
    output logic [7:0]      alpha_out,
    output logic            out_of_range
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * 4;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [8:0]  eff_w;
    logic [8:0]  eff_h;
    logic        fmt_ok;
    logic        has_alpha;

    logic        req_reg;
    logic [7:0]  x_reg;
    logic [7:0]  y_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  alpha_reg;
    logic        oor_reg;

    logic [16:0] pix_reg;
    logic [18:0] base_reg;
    logic [18:0] base_next;
    logic [ADDR_W-1:0] addr;

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rdata_reg;
    logic [7:0]  src_sel;
    logic [7:0]  wdata;

    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic [17:0]        prod_mag;
    logic               neg_reg;
    logic [15:0]        mag_reg;
    logic [23:0]        recip;
    logic [7:0]         q0;
    logic [16:0]        rem;
    logic [7:0]         quot;
    logic [7:0]         blend_reg;

    logic [7:0]  res_reg [4];
    logic        done_reg;
    logic [7:0]  red_out_reg;
    logic [7:0]  green_out_reg;
    logic [7:0]  blue_out_reg;
    logic [7:0]  alpha_out_reg;
    logic        oor_out_reg;

    // Geometry above the store size is clamped to the store size.
    assign eff_w     = (int'(width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : width;
    assign eff_h     = (int'(height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : height;
    assign fmt_ok    = (fmt <= FMT_ABGR);
    assign has_alpha = fmt_has_alpha(fmt);

    assign stat.skip      = oor_reg || !fmt_ok;
    assign stat.is_get    = (req_reg == REQ_GET);
    assign stat.has_alpha = has_alpha;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            x_reg     <= x_pos;
            y_reg     <= y_pos;
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
            alpha_reg <= alpha_in;
            oor_reg   <= ({1'b0, x_pos} >= eff_w) || ({1'b0, y_pos} >= eff_h);
        end
        if (cmd.mul_y)
        begin
            pix_reg <= 17'(y_reg) * 17'(eff_w) + 17'(x_reg);
        end
        if (cmd.base)
        begin
            base_reg <= base_next;
        end
    end

    assign base_next = has_alpha ? {pix_reg, 2'b00}
                                 : ({1'b0, pix_reg, 1'b0} + {2'b00, pix_reg});
    assign addr = ADDR_W'(base_reg + 19'(chan_pos(fmt, cmd.ch)));

    always_comb
    begin
        case (cmd.ch)
            CH_RED:   src_sel = red_reg;
            CH_GREEN: src_sel = green_reg;
            CH_BLUE:  src_sel = blue_reg;
            default:  src_sel = ALPHA_OPAQUE;
        endcase
    end

    always_comb
    begin
        if (cmd.ch == CH_ALPHA)
        begin
            wdata = ALPHA_OPAQUE;
        end
        else if (has_alpha)
        begin
            wdata = blend_reg;
        end
        else
        begin
            wdata = src_sel;
        end
    end

    // Single-port byte store with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // Blend: alpha * (src - dest) as sign and magnitude.
    assign diff     = $signed({1'b0, src_sel}) - $signed({1'b0, rdata_reg});
    assign prod     = $signed({10'd0, alpha_reg}) * 18'(diff);
    assign prod_mag = prod[17] ? 18'(-prod) : 18'(prod);

    // Divide by 255 through the reciprocal 257/65536, then one correction step.
    assign recip = {mag_reg, 8'd0} + 24'(mag_reg);
    assign q0    = recip[23:16];
    assign rem   = 17'(mag_reg) - ({1'b0, q0, 8'd0} - 17'(q0));
    assign quot  = (rem >= 17'd255) ? q0 + 8'd1 : q0;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            neg_reg <= prod[17];
            mag_reg <= prod_mag[15:0];
        end
        if (cmd.div)
        begin
            blend_reg <= neg_reg ? rdata_reg - quot : rdata_reg + quot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_reg[0] <= '0;
            res_reg[1] <= '0;
            res_reg[2] <= '0;
            res_reg[3] <= '0;
        end
        else if (cmd.cap)
        begin
            res_reg[cmd.ch] <= rdata_reg;
        end
        if (cmd.emit)
        begin
            red_out_reg   <= res_reg[0];
            green_out_reg <= res_reg[1];
            blue_out_reg  <= res_reg[2];
            alpha_out_reg <= (stat.is_get && !stat.skip && !has_alpha) ? ALPHA_OPAQUE
                                                                       : res_reg[3];
            oor_out_reg   <= oor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    assign done         = done_reg;
    assign red_out      = red_out_reg;
    assign green_out    = green_out_reg;
    assign blue_out     = blue_out_reg;
    assign alpha_out    = alpha_out_reg;
    assign out_of_range = oor_out_reg;

endmodule

`default_nettype wire

@@ hdl/pixel_store_with_alpha_blend.sv @@
// Top level: configuration registers, controller and datapath of the pixel store.
`default_nettype none

// Pixel store with alpha blend.
// Requests enter on start when busy is low; each transaction is a put or a get
// of one pixel at (x_pos, y_pos). Exactly one result follows each transaction:
// done is high for one cycle with the channel and out_of_range fields valid.
// The receiver cannot stall; a result is simply taken in its done cycle.
// Each channel is handled in turn through the single-port byte store: a put to a
// four-byte format reads, multiplies, divides and writes each colour byte and then
// writes alpha as opaque without a read; a put to a three-byte format only writes;
// a get reads and captures each byte; out-of-range coordinates or an undefined
// format skip the store.
// done rises as busy falls, and a new start is taken in that same cycle.
// Configuration is to be written over the APB port only while the block is idle;
// the block itself does not enforce this.
// Reset sets format RGBA and a 256 by 256 surface; the store itself is not
// cleared and holds no meaningful data until pixels are put.

module pixel_store_with_alpha_blend
    import pxab_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [7:0]  x_pos,
    input  wire logic [7:0]  y_pos,
    input  wire logic [7:0]  red_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  blue_in,
    input  wire logic [7:0]  alpha_in,
    output logic             done,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    output logic [7:0]       alpha_out,
    output logic             out_of_range
);

    logic [2:0] fmt_reg;
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    pxab_cmd_t  cmd;
    pxab_stat_t stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_FORMAT: fmt_reg    <= pwdata[2:0];
                REG_WIDTH:  width_reg  <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[8:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FORMAT: prdata = {29'd0, fmt_reg};
            REG_WIDTH:  prdata = {23'd0, width_reg};
            REG_HEIGHT: prdata = {23'd0, height_reg};
            default:    prdata = '0;
        endcase
    end

    pxab_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    pxab_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .fmt          (fmt_reg),
        .width        (width_reg),
        .height       (height_reg),
        .req_type     (req_type),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .alpha_in     (alpha_in),
        .done         (done),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .alpha_out    (alpha_out),
        .out_of_range (out_of_range)
    );

endmodule

`default_nettype wire

@@ test/pixel_store_with_alpha_blend_tb.sv @@
// Self-checking testbench for the pixel store with alpha blend, with its own pixel predictor.
module pixel_store_with_alpha_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pxab_pkg::*;

    localparam int STORE_BYTES = 256 * 256 * 4;
    localparam int LOW_PIXELS = 300;
    localparam int FILL_PIXELS = 400;
    localparam int RANDOM_ITEMS = 2000;
    localparam int LAST_STRETCH = 150;
    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic       req;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       oor;
    } pixel_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic        req_type = REQ_PUT;
    logic [7:0]  x_pos = '0;
    logic [7:0]  y_pos = '0;
    logic [7:0]  red_in = '0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic [7:0]  alpha_in = '0;
    logic        done;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        out_of_range;

    // Predicted surface content and the bytes that the stimulus has written so far.
    logic [7:0]   pixel_bytes [STORE_BYTES];
    bit           byte_written [STORE_BYTES];
    logic [2:0]   fmt_cfg = FMT_RESET;
    logic [8:0]   width_cfg = WIDTH_RESET;
    logic [8:0]   height_cfg = HEIGHT_RESET;

    pixel_req_t   pending_requests [$];
    pixel_res_t   expected_pixels [$];
    int           errors = 0;
    int           idle_pct = 25;
    int           gap_left = 0;
    bit           steady = 1'b0;
    bit           accepted = 1'b0;

    pixel_store_with_alpha_blend dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .alpha_in     (alpha_in),
        .done         (done),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .alpha_out    (alpha_out),
        .out_of_range (out_of_range)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        if (errors < PRINT_LIMIT)
            $display("%0t: %s: got %0h, expected %0h", $realtime, what, got_v, want_v);
        errors++;
    endtask

    // Byte offset of a channel inside one pixel; alpha has no byte in RGB and BGR.
    function automatic logic [1:0] chan_offset(input logic [2:0] fmt, input logic [1:0] ch);
        logic [7:0] ofs;
        case (fmt)
            FMT_RGB, FMT_RGBA: ofs = {2'd3, 2'd2, 2'd1, 2'd0};
            FMT_ARGB:          ofs = {2'd0, 2'd3, 2'd2, 2'd1};
            FMT_BGR, FMT_BGRA: ofs = {2'd3, 2'd0, 2'd1, 2'd2};
            FMT_ABGR:          ofs = {2'd0, 2'd1, 2'd2, 2'd3};
            default:           ofs = '0;
        endcase
        return ofs[2 * ch +: 2];
    endfunction

    function automatic bit is_alpha_fmt(input logic [2:0] fmt);
        return fmt != FMT_RGB && fmt != FMT_BGR;
    endfunction

    function automatic int clamp_dim(input logic [8:0] d);
        return (d > 9'd256) ? 256 : int'(d);
    endfunction

    // dest + alpha * (src - dest) / 255, with the quotient truncated toward zero.
    function automatic logic [7:0] blend_channel(input logic [7:0] dst, input logic [7:0] src,
                                                 input logic [7:0] alpha);
        int diff;
        int q;
        diff = int'(src) - int'(dst);
        q = (int'(alpha) * diff) / 255;
        return 8'(int'(dst) + q);
    endfunction

    function automatic pixel_res_t apply_request(input pixel_req_t q);
        pixel_res_t res;
        int         ew;
        int         eh;
        int         base;
        int         ch;
        bit         alpha_fmt;
        logic [7:0] src [3];
        res = '0;
        ew = clamp_dim(width_cfg);
        eh = clamp_dim(height_cfg);
        res.oor = (q.x >= ew) || (q.y >= eh);
        if (!res.oor && fmt_cfg <= FMT_ABGR) begin
            alpha_fmt = is_alpha_fmt(fmt_cfg);
            base = (q.y * ew + q.x) * (alpha_fmt ? 4 : 3);
            src[0] = q.red;
            src[1] = q.green;
            src[2] = q.blue;
            if (q.req == REQ_PUT) begin
                for (ch = 0; ch < 3; ch++) begin
                    if (alpha_fmt)
                        pixel_bytes[base + chan_offset(fmt_cfg, 2'(ch))] = blend_channel(
                            pixel_bytes[base + chan_offset(fmt_cfg, 2'(ch))], src[ch], q.alpha);
                    else
                        pixel_bytes[base + chan_offset(fmt_cfg, 2'(ch))] = src[ch];
                end
                if (alpha_fmt)
                    pixel_bytes[base + chan_offset(fmt_cfg, CH_ALPHA)] = ALPHA_OPAQUE;
            end else begin
                res.red = pixel_bytes[base + chan_offset(fmt_cfg, CH_RED)];
                res.green = pixel_bytes[base + chan_offset(fmt_cfg, CH_GREEN)];
                res.blue = pixel_bytes[base + chan_offset(fmt_cfg, CH_BLUE)];
                res.alpha = alpha_fmt ? pixel_bytes[base + chan_offset(fmt_cfg, CH_ALPHA)]
                                      : ALPHA_OPAQUE;
            end
        end
        return res;
    endfunction

    // Returns 0 if the request would read a byte never written; else records its writes.
    function automatic bit claim_bytes(input pixel_req_t q);
        int ew;
        int eh;
        int base;
        int ch;
        bit alpha_fmt;
        ew = clamp_dim(width_cfg);
        eh = clamp_dim(height_cfg);
        if (q.x >= ew || q.y >= eh || fmt_cfg > FMT_ABGR)
            return 1'b1;
        alpha_fmt = is_alpha_fmt(fmt_cfg);
        base = (q.y * ew + q.x) * (alpha_fmt ? 4 : 3);
        if (q.req == REQ_GET || alpha_fmt) begin
            for (ch = 0; ch < 3; ch++)
                if (!byte_written[base + chan_offset(fmt_cfg, 2'(ch))])
                    return 1'b0;
            if (q.req == REQ_GET && alpha_fmt && !byte_written[base + chan_offset(fmt_cfg, CH_ALPHA)])
                return 1'b0;
        end
        if (q.req == REQ_PUT)
            for (ch = 0; ch < (alpha_fmt ? 4 : 3); ch++)
                byte_written[base + chan_offset(fmt_cfg, 2'(ch))] = 1'b1;
        return 1'b1;
    endfunction

    function automatic pixel_req_t make_req(input logic req, input logic [7:0] x,
                                            input logic [7:0] y, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [7:0] a);
        return {req, x, y, r, g, b, a};
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [8:0] pick_dim();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 9'd0;
        if (r <= 2) return 9'd1;
        if (r <= 4) return 9'd256;
        if (r == 5) return 9'($urandom_range(257, 511));
        if (r <= 10) return 9'($urandom_range(2, 16));
        return 9'($urandom_range(1, 256));
    endfunction

    task automatic queue_request(input pixel_req_t q);
        if (claim_bytes(q))
            pending_requests.push_back(q);
    endtask

    // Most coordinates land on the surface, biased to the low pixels that every
    // format can read safely; a few are drawn over the whole coordinate range.
    task automatic queue_random_request();
        pixel_req_t q;
        int         ew;
        int         span;
        int         low;
        int         p;
        q.req = 1'($urandom_range(0, 1));
        q.red = rand_byte();
        q.green = rand_byte();
        q.blue = rand_byte();
        q.alpha = rand_byte();
        ew = clamp_dim(width_cfg);
        span = ew * clamp_dim(height_cfg);
        low = (span < LOW_PIXELS) ? span : LOW_PIXELS;
        if (span == 0 || $urandom_range(0, 7) == 0) begin
            q.x = 8'($urandom_range(0, 255));
            q.y = 8'($urandom_range(0, 255));
        end else begin
            p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1)
                                            : $urandom_range(0, low - 1);
            q.x = 8'(p % ew);
            q.y = 8'(p / ew);
        end
        if (!claim_bytes(q)) begin
            p = $urandom_range(0, low - 1);
            q.x = 8'(p % ew);
            q.y = 8'(p / ew);
            void'(claim_bytes(q));
        end
        pending_requests.push_back(q);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_FORMAT: fmt_cfg = value[2:0];
            REG_WIDTH:  width_cfg = value[8:0];
            REG_HEIGHT: height_cfg = value[8:0];
            default: ;
        endcase
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
            report_mismatch("register readback", prdata, value);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Sampled at the rising edge, where neither the driver nor the queue filler acts.
    task automatic drain();
        while (pending_requests.size() != 0 || start || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    always @(posedge clk) begin
        pixel_res_t got;
        pixel_res_t want;
        accepted = start && !busy;
        if (rst_n && done) begin
            got = {red_out, green_out, blue_out, alpha_out, out_of_range};
            if (expected_pixels.size() == 0) begin
                report_mismatch("done with no transaction outstanding", 1, 0);
            end else begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red) report_mismatch("red_out", got.red, want.red);
                if (got.green !== want.green) report_mismatch("green_out", got.green, want.green);
                if (got.blue !== want.blue) report_mismatch("blue_out", got.blue, want.blue);
                if (got.alpha !== want.alpha) report_mismatch("alpha_out", got.alpha, want.alpha);
                if (got.oor !== want.oor) report_mismatch("out_of_range", got.oor, want.oor);
            end
        end
        if (rst_n && accepted)
            expected_pixels.push_back(apply_request(
                {req_type, x_pos, y_pos, red_in, green_in, blue_in, alpha_in}));
    end

    always @(negedge clk) begin
        pixel_req_t q;
        if (rst_n && (!start || accepted)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                q = pending_requests.pop_front();
                req_type <= q.req;
                x_pos <= q.x;
                y_pos <= q.y;
                red_in <= q.red;
                green_in <= q.green;
                blue_in <= q.blue;
                alpha_in <= q.alpha;
                start <= 1'b1;
                if (!steady && $urandom_range(1, 100) <= idle_pct)
                    gap_left = $urandom_range(1, 5);
            end else begin
                start <= 1'b0;
            end
        end
    end

    initial begin
        int issued;
        int phase_len;
        int p;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Three-byte format on the full surface, including the far corner.
        set_reg(REG_FORMAT, FMT_RGB);
        set_reg(REG_WIDTH, 256);
        set_reg(REG_HEIGHT, 256);
        queue_request(make_req(REQ_PUT, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_request(make_req(REQ_PUT, 1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        queue_request(make_req(REQ_PUT, 2, 0, 8'h0A, 8'h80, 8'hF0, 8'h33));
        queue_request(make_req(REQ_PUT, 3, 0, 8'h55, 8'hAA, 8'h01, 8'h00));
        queue_request(make_req(REQ_PUT, 255, 255, 8'h12, 8'h34, 8'h56, 8'hFF));
        queue_request(make_req(REQ_GET, 255, 255, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        queue_request(make_req(REQ_GET, 2, 0, 8'h00, 8'h00, 8'h00, 8'h00));
        drain();

        // Alpha format over the same bytes: zero weight, full weight, truncation toward zero.
        set_reg(REG_FORMAT, FMT_RGBA);
        set_reg(REG_HEIGHT, 2);
        queue_request(make_req(REQ_GET, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_request(make_req(REQ_PUT, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        queue_request(make_req(REQ_PUT, 1, 0, 8'h00, 8'h00, 8'h00, 8'hFF));
        queue_request(make_req(REQ_PUT, 2, 0, 8'h00, 8'hFF, 8'h7F, 8'h01));
        queue_request(make_req(REQ_GET, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_request(make_req(REQ_GET, 1, 0, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_request(make_req(REQ_GET, 2, 0, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_request(make_req(REQ_PUT, 0, 2, 8'h11, 8'h22, 8'h33, 8'h80));
        queue_request(make_req(REQ_GET, 9, 2, 8'h00, 8'h00, 8'h00, 8'h00));
        drain();

        // Zero width puts everything out of range; undefined formats touch nothing.
        set_reg(REG_FORMAT, 3'd7);
        set_reg(REG_WIDTH, 0);
        queue_request(make_req(REQ_PUT, 0, 0, 8'hFF, 8'h00, 8'hFF, 8'hFF));
        queue_request(make_req(REQ_GET, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00));
        drain();
        set_reg(REG_FORMAT, 3'd6);
        set_reg(REG_WIDTH, 511);
        set_reg(REG_HEIGHT, 1);
        queue_request(make_req(REQ_GET, 255, 0, 8'h00, 8'h00, 8'h00, 8'h00));
        queue_request(make_req(REQ_PUT, 255, 0, 8'hAB, 8'hCD, 8'hEF, 8'h40));
        queue_request(make_req(REQ_GET, 0, 1, 8'h00, 8'h00, 8'h00, 8'h00));
        drain();

        // Fill the low bytes so that any format can blend and read them later.
        set_reg(REG_FORMAT, FMT_RGB);
        set_reg(REG_WIDTH, 256);
        set_reg(REG_HEIGHT, 256);
        for (p = 0; p < FILL_PIXELS; p++)
            queue_request(make_req(REQ_PUT, 8'(p % 256), 8'(p / 256),
                                   rand_byte(), rand_byte(), rand_byte(), rand_byte()));
        drain();

        issued = FILL_PIXELS;
        while (issued < RANDOM_ITEMS) begin
            set_reg(REG_FORMAT, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                            : 3'($urandom_range(0, 5)));
            set_reg(REG_WIDTH, pick_dim());
            set_reg(REG_HEIGHT, pick_dim());
            idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
            phase_len = $urandom_range(20, 80);
            if (RANDOM_ITEMS - issued <= LAST_STRETCH) begin
                steady = 1'b1;
                phase_len = RANDOM_ITEMS - issued;
            end
            repeat (phase_len) queue_random_request();
            issued += phase_len;
            drain();
        end

        if (errors == 0)
            $display("pixel_store_with_alpha_blend_tb OK");
        else
            $display("pixel_store_with_alpha_blend_tb NOT OK");
        $finish;
    end

    initial begin
        #5ms;
        $display("pixel_store_with_alpha_blend_tb NOT OK");
        $finish;
    end

endmodule

@@ pixel_store_with_alpha_blend.f @@
hdl/pxab_pkg.sv
hdl/pxab_ctrl.sv
hdl/pxab_dp.sv
hdl/pixel_store_with_alpha_blend.sv
test/pixel_store_with_alpha_blend_tb.sv
